>>> src/bbds_pkg.sv
// Shared types, constants and the duty step function for the buck/boost duty stepper.
`timescale 1ns / 1ps
`default_nettype none

package bbds_pkg;

   // Field widths
   localparam int SAMPLE_BITS = 12;
   localparam int DUTY_BITS   = 14;
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;
   localparam int REQ_DATA_BITS = 40;
   localparam int RSP_DATA_BITS = 32;

   typedef logic [SAMPLE_BITS-1:0] sample_type;
   typedef logic [DUTY_BITS-1:0]   duty_type;

   // Duty ceilings in hundredths of a percent
   localparam duty_type BUCK_DUTY_MAX  = DUTY_BITS'(10000);
   localparam duty_type BOOST_DUTY_MAX = DUTY_BITS'(9000);

   // Register reset values
   localparam sample_type BUCK_SETPOINT_RESET  = SAMPLE_BITS'(2068);
   localparam sample_type BOOST_SETPOINT_RESET = SAMPLE_BITS'(2895);
   localparam sample_type SOLAR_MINIMUM_RESET  = SAMPLE_BITS'(1737);
   localparam duty_type   BUCK_STEP_RESET      = DUTY_BITS'(1000);
   localparam duty_type   BOOST_STEP_RESET     = DUTY_BITS'(1000);

   // Register indexes (byte address divided by four)
   typedef enum logic [2:0] {
      REG_BUCK_SETPOINT  = 3'd0,
      REG_BOOST_SETPOINT = 3'd1,
      REG_SOLAR_MINIMUM  = 3'd2,
      REG_BUCK_STEP      = 3'd3,
      REG_BOOST_STEP     = 3'd4,
      REG_BUCK_ENABLE    = 3'd5
   } reg_index_type;

   // One bang-bang step of a duty value toward its setpoint, saturating at
   // the limit on the way up and at zero on the way down.
   function automatic duty_type step_duty(duty_type duty, sample_type sample,
                                          sample_type target, duty_type inc,
                                          duty_type limit);
      logic [DUTY_BITS:0] sum;
      duty_type           result;
      sum    = {1'b0, duty} + {1'b0, inc};
      result = duty;
      if (sample < target) begin
         result = (sum <= {1'b0, limit}) ? sum[DUTY_BITS-1:0] : limit;
      end else if (sample > target) begin
         result = (duty >= inc) ? duty - inc : '0;
      end
      return result;
   endfunction

endpackage

`default_nettype wire

>>> src/buck_boost_duty_stepper.sv
// Top level of the buck/boost duty stepper: register file, duty loops and output stage.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one sample set (solar, boost output, buck output) per
// transaction and returns one result transaction with the new buck duty, the
// applied boost duty and a boost-active flag. For each transaction the saturating
// step of both duty loops is computed from the incoming samples and the stored
// duties, and lands in the result register, so one transaction is accepted in
// every cycle while the result side keeps taking them. The result is valid in
// the cycle after its sample set is accepted. Both stored duties reset to zero;
// the configuration registers reset to their documented defaults. The user is
// to write them only while no transaction is in flight; the block does not enforce it.
module buck_boost_duty_stepper
   import bbds_pkg::*;
(
   input  wire                          clock,
   input  wire                          reset,
   // Sample set channel
   input  wire                          req_tvalid,
   output logic                         req_tready,
   input  wire  [REQ_DATA_BITS-1:0]     req_tdata,   // solar_sample, boost_sample, buck_sample
   // Result channel
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   output logic [RSP_DATA_BITS-1:0]     rsp_tdata,   // buck_duty_out, boost_duty_out
   output logic                         rsp_tuser,   // boost_active
   // Configuration port
   input  wire                          csr_psel,
   input  wire                          csr_penable,
   input  wire                          csr_pwrite,
   input  wire  [CSR_ADDR_BITS-1:0]     csr_paddr,
   input  wire  [CSR_DATA_BITS-1:0]     csr_pwdata,
   output logic [CSR_DATA_BITS-1:0]     csr_prdata,
   output logic                         csr_pready
);

   // Configuration registers
   sample_type buck_setpoint_ff, boost_setpoint_ff, solar_minimum_ff;
   duty_type   buck_step_ff, boost_step_ff;
   logic       buck_enable_ff;

   // Loop state
   duty_type   buck_duty_ff, boost_duty_ff;
   duty_type   buck_duty_in, boost_duty_in;

   // Result register
   logic       rsp_valid_ff, rsp_valid_in;
   duty_type   rsp_buck_ff, rsp_boost_ff;
   duty_type   rsp_buck_in, rsp_boost_in;
   logic       rsp_active_ff, rsp_active_in;

   logic          csr_write;
   reg_index_type csr_index;
   logic          req_accept;
   sample_type    solar_sample, boost_sample, buck_sample;
   sample_type    buck_target;
   logic          boost_active;

   // Register access decode
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[CSR_ADDR_BITS-1:2]);

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         buck_setpoint_ff  <= BUCK_SETPOINT_RESET;
         boost_setpoint_ff <= BOOST_SETPOINT_RESET;
         solar_minimum_ff  <= SOLAR_MINIMUM_RESET;
         buck_step_ff      <= BUCK_STEP_RESET;
         boost_step_ff     <= BOOST_STEP_RESET;
         buck_enable_ff    <= 1'b1;
      end else if (csr_write) begin
         case (csr_index)
            REG_BUCK_SETPOINT:  buck_setpoint_ff  <= csr_pwdata[SAMPLE_BITS-1:0];
            REG_BOOST_SETPOINT: boost_setpoint_ff <= csr_pwdata[SAMPLE_BITS-1:0];
            REG_SOLAR_MINIMUM:  solar_minimum_ff  <= csr_pwdata[SAMPLE_BITS-1:0];
            REG_BUCK_STEP:      buck_step_ff      <= csr_pwdata[DUTY_BITS-1:0];
            REG_BOOST_STEP:     boost_step_ff     <= csr_pwdata[DUTY_BITS-1:0];
            REG_BUCK_ENABLE:    buck_enable_ff    <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // Register reads
   always_comb begin
      csr_prdata = '0;
      case (csr_index)
         REG_BUCK_SETPOINT:  csr_prdata = CSR_DATA_BITS'(buck_setpoint_ff);
         REG_BOOST_SETPOINT: csr_prdata = CSR_DATA_BITS'(boost_setpoint_ff);
         REG_SOLAR_MINIMUM:  csr_prdata = CSR_DATA_BITS'(solar_minimum_ff);
         REG_BUCK_STEP:      csr_prdata = CSR_DATA_BITS'(buck_step_ff);
         REG_BOOST_STEP:     csr_prdata = CSR_DATA_BITS'(boost_step_ff);
         REG_BUCK_ENABLE:    csr_prdata = CSR_DATA_BITS'(buck_enable_ff);
         default:            csr_prdata = '0;
      endcase
   end

   // A new transaction enters whenever the result register is free or drains.
   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign req_accept = req_tvalid & req_tready;

   assign solar_sample = req_tdata[SAMPLE_BITS-1:0];
   assign boost_sample = req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
   assign buck_sample  = req_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS];

   // Duty loop steps; a disabled buck loop regulates toward zero, and the
   // boost loop holds its duty while solar is below the minimum.
   always_comb begin
      buck_target  = buck_enable_ff ? buck_setpoint_ff : '0;
      boost_active = solar_sample >= solar_minimum_ff;
      buck_duty_in = buck_duty_ff;
      boost_duty_in = boost_duty_ff;
      if (req_accept) begin
         buck_duty_in = step_duty(buck_duty_ff, buck_sample, buck_target,
                                  buck_step_ff, BUCK_DUTY_MAX);
         if (boost_active) begin
            boost_duty_in = step_duty(boost_duty_ff, boost_sample, boost_setpoint_ff,
                                      boost_step_ff, BOOST_DUTY_MAX);
         end
      end
   end

   // Result register next values
   always_comb begin
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_buck_in   = rsp_buck_ff;
      rsp_boost_in  = rsp_boost_ff;
      rsp_active_in = rsp_active_ff;
      if (req_accept) begin
         rsp_valid_in  = 1'b1;
         rsp_buck_in   = buck_duty_in;
         rsp_boost_in  = boost_active ? boost_duty_in : '0;
         rsp_active_in = boost_active;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         buck_duty_ff  <= '0;
         boost_duty_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         buck_duty_ff  <= buck_duty_in;
         boost_duty_ff <= boost_duty_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      rsp_buck_ff   <= rsp_buck_in;
      rsp_boost_ff  <= rsp_boost_in;
      rsp_active_ff <= rsp_active_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'({rsp_boost_ff, rsp_buck_ff});
   assign rsp_tuser  = rsp_active_ff;

endmodule

`default_nettype wire

>>> bench/buck_boost_duty_stepper_tb.sv
// Self-checking testbench for the buck/boost duty stepper with streaming and register traffic.
`timescale 1ns / 1ps

module buck_boost_duty_stepper_tb;
   import bbds_pkg::*;

   // One ADC sample set as it travels on the input channel.
   typedef struct {
      sample_type solar;
      sample_type boost;
      sample_type buck;
   } sample_set_type;

   // One result transaction as the duty loops should produce it.
   typedef struct {
      duty_type buck_duty;
      duty_type boost_duty;
      logic     boost_on;
   } duty_result_type;

   localparam int LONG_HOLD_CYCLES = 150;

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;   // solar_sample, boost_sample, buck_sample
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;        // buck_duty_out, boost_duty_out
   logic                     rsp_tuser;        // boost_active
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   // Predictor copy of the configuration registers and the two stored duties.
   sample_type cfg_buck_setpoint  = BUCK_SETPOINT_RESET;
   sample_type cfg_boost_setpoint = BOOST_SETPOINT_RESET;
   sample_type cfg_solar_minimum  = SOLAR_MINIMUM_RESET;
   duty_type   cfg_buck_step      = BUCK_STEP_RESET;
   duty_type   cfg_boost_step     = BOOST_STEP_RESET;
   logic       cfg_buck_enable    = 1'b1;
   duty_type   buck_duty_now;
   duty_type   boost_duty_now;

   sample_set_type  pending_sets[$];
   duty_result_type expected_duties[$];
   int              sets_queued = 0;
   int              sets_accepted = 0;
   int              error_count = 0;

   // Traffic shaping controls, changed by the stimulus process between phases.
   logic send_gaps_on = 1'b1;
   logic recv_gaps_on = 1'b1;
   int   long_hold_requests = 0;
   int   long_holds_done = 0;
   int   send_gap = 0;
   int   recv_stall = 0;

   buck_boost_duty_stepper dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Saturating bang-bang step of one duty toward its target.
   function automatic duty_type next_duty(duty_type duty, sample_type feedback,
                                          sample_type target, duty_type inc,
                                          duty_type ceiling);
      int d;
      d = int'(duty);
      if (feedback < target) begin
         d = (d + int'(inc) > int'(ceiling)) ? int'(ceiling) : d + int'(inc);
      end else if (feedback > target) begin
         d = (d >= int'(inc)) ? d - int'(inc) : 0;
      end
      return duty_type'(d);
   endfunction

   // Idle length: mostly none or short, now and then a long one.
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   // Sample biased toward a threshold so that holds and both step directions occur.
   function automatic sample_type pick_sample(sample_type target);
      int r;
      int v;
      r = $urandom_range(0, 99);
      if (r < 35) begin
         return sample_type'($urandom_range(0, 4095));
      end else if (r < 55) begin
         return target;
      end else if (r < 85) begin
         v = int'(target) + int'($urandom_range(0, 80)) - 40;
         if (v < 0) v = 0;
         if (v > 4095) v = 4095;
         return sample_type'(v);
      end else if (r < 93) begin
         return '0;
      end
      return '1;
   endfunction

   // Step size: zero, full range, small or moderate.
   function automatic duty_type pick_step();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         return '0;
      end else if (r == 1) begin
         return duty_type'(10000);
      end else if (r < 6) begin
         return duty_type'($urandom_range(1, 300));
      end
      return duty_type'($urandom_range(1, 3000));
   endfunction

   // Register write: setup cycle, then access cycle until pready.
   task automatic csr_write(reg_index_type idx, logic [CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_BITS'({idx, 2'b00});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_BUCK_SETPOINT:  cfg_buck_setpoint  = value[SAMPLE_BITS-1:0];
         REG_BOOST_SETPOINT: cfg_boost_setpoint = value[SAMPLE_BITS-1:0];
         REG_SOLAR_MINIMUM:  cfg_solar_minimum  = value[SAMPLE_BITS-1:0];
         REG_BUCK_STEP:      cfg_buck_step      = value[DUTY_BITS-1:0];
         REG_BOOST_STEP:     cfg_boost_step     = value[DUTY_BITS-1:0];
         REG_BUCK_ENABLE:    cfg_buck_enable    = value[0];
         default: ;
      endcase
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic apply_settings(int buck_sp, int boost_sp, int solar_min,
                                 int buck_inc, int boost_inc, int enable);
      csr_write(REG_BUCK_SETPOINT, buck_sp);
      csr_write(REG_BOOST_SETPOINT, boost_sp);
      csr_write(REG_SOLAR_MINIMUM, solar_min);
      csr_write(REG_BUCK_STEP, buck_inc);
      csr_write(REG_BOOST_STEP, boost_inc);
      csr_write(REG_BUCK_ENABLE, enable);
   endtask

   task automatic queue_set(int solar, int boost, int buck);
      sample_set_type s;
      s.solar = sample_type'(solar);
      s.boost = sample_type'(boost);
      s.buck  = sample_type'(buck);
      pending_sets.push_back(s);
      sets_queued++;
   endtask

   // Wait until every queued set has been taken and every result has come back.
   task automatic wait_drained();
      do @(negedge clock);
      while (sets_accepted != sets_queued || expected_duties.size() != 0);
   endtask

   // Sample set driver.
   always @(posedge clock) begin : sample_driver
      sample_set_type s;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else if (!req_tvalid || req_tready) begin
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_sets.size() > 0) begin
            s = pending_sets.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {4'b0, s.buck, s.boost, s.solar};
            if (send_gaps_on && $urandom_range(0, 2) == 0) send_gap = gap_len();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result receiver: random stalls plus long hold-offs on request.
   always @(posedge clock) begin : result_receiver
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (recv_stall > 0) begin
         recv_stall--;
         rsp_tready <= 1'b0;
      end else if (long_holds_done != long_hold_requests) begin
         long_holds_done++;
         recv_stall = LONG_HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (recv_gaps_on && $urandom_range(0, 3) == 0) begin
         recv_stall = gap_len();
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Predicts the duties for each accepted sample set and checks each result.
   always @(posedge clock) begin : duty_monitor
      sample_type      solar;
      sample_type      boost;
      sample_type      buck;
      sample_type      buck_target;
      logic            boost_on;
      duty_result_type want;
      if (reset) begin
         buck_duty_now  = '0;
         boost_duty_now = '0;
      end else begin
         if (req_tvalid && req_tready) begin
            solar = req_tdata[11:0];
            boost = req_tdata[23:12];
            buck  = req_tdata[35:24];
            buck_target = cfg_buck_enable ? cfg_buck_setpoint : '0;
            boost_on = (solar >= cfg_solar_minimum);
            buck_duty_now = next_duty(buck_duty_now, buck, buck_target, cfg_buck_step,
                                      BUCK_DUTY_MAX);
            if (boost_on) begin
               boost_duty_now = next_duty(boost_duty_now, boost, cfg_boost_setpoint,
                                          cfg_boost_step, BOOST_DUTY_MAX);
            end
            want.buck_duty  = buck_duty_now;
            want.boost_duty = boost_on ? boost_duty_now : '0;
            want.boost_on   = boost_on;
            expected_duties.push_back(want);
            sets_accepted++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_duties.size() == 0) begin
               $display("%0t: result transaction with no expectation: tdata %h tuser %b",
                        $time, rsp_tdata, rsp_tuser);
               error_count++;
            end else begin
               want = expected_duties.pop_front();
               if (rsp_tdata[13:0] !== want.buck_duty) begin
                  $display("%0t: buck_duty_out expected %0d actual %0d",
                           $time, want.buck_duty, rsp_tdata[13:0]);
                  error_count++;
               end
               if (rsp_tdata[27:14] !== want.boost_duty) begin
                  $display("%0t: boost_duty_out expected %0d actual %0d",
                           $time, want.boost_duty, rsp_tdata[27:14]);
                  error_count++;
               end
               if (rsp_tuser !== want.boost_on) begin
                  $display("%0t: boost_active expected %b actual %b",
                           $time, want.boost_on, rsp_tuser);
                  error_count++;
               end
            end
         end
      end
   end

   // Stimulus: directed sets under reset settings, then phases with directed and random settings.
   initial begin : stimulus
      int phase;
      int count;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed sets against the reset thresholds.
      @(negedge clock);
      queue_set(0, 0, 0);
      queue_set(4095, 4095, 4095);
      queue_set(1737, 2895, 2068);
      queue_set(1736, 0, 2068);
      for (int i = 0; i < 11; i++) queue_set(4095, 0, 0);
      queue_set(12'hAAA, 12'h555, 12'hAAA);
      queue_set(12'h555, 12'hAAA, 12'h555);
      queue_set(4095, 2895, 2069);
      queue_set(1737, 2896, 2067);
      queue_set(1736, 4095, 4095);
      queue_set(4095, 4095, 4095);
      queue_set(1737, 2894, 2068);
      wait_drained();

      for (phase = 0; phase < 9; phase++) begin
         // Let the block settle before writing the registers.
         repeat (3) @(posedge clock);
         if (phase == 0) begin
            apply_settings(4095, 4095, 0, 10000, 10000, 1);
         end else if (phase == 1) begin
            apply_settings(0, 0, 4095, 0, 0, 0);
         end else if (phase == 2) begin
            apply_settings(2048, 2048, 0, 10000, 10000, 0);
         end else begin
            apply_settings($urandom_range(0, 4095), $urandom_range(0, 4095),
                           $urandom_range(0, 4095), pick_step(), pick_step(),
                           ($urandom_range(0, 3) != 0));
         end

         @(negedge clock);
         send_gaps_on = (phase != 4 && phase != 5);
         recv_gaps_on = (phase != 5);
         if (phase == 4) long_hold_requests++;
         count = (phase < 3) ? 20 : 58;
         for (int i = 0; i < count; i++) begin
            queue_set(pick_sample(cfg_solar_minimum), pick_sample(cfg_boost_setpoint),
                      pick_sample(cfg_buck_enable ? cfg_buck_setpoint : '0));
         end
         wait_drained();
      end

      repeat (10) @(posedge clock);
      if (error_count == 0 && expected_duties.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin : watchdog
      #(5_000_000);
      $display("Verification failed");
      $finish;
   end

endmodule
